FILE: hw/rtl/four_digit_seven_segment_driver_top_assert.svh
// assertion macros shared by the display driver modules
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_DRIVER_TOP_ASSERT_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_DRIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fsd assertion failed");
`define FSD_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("fsd assertion failed");
`else
`define FSD_ASSERT(lbl, clk, rst_n, prop)
`define FSD_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/fsd_pkg.sv
// types, constants and font for the four-digit display driver
package fsd_pkg;

    localparam int VALUE_W = 17;

    localparam logic [1:0] MODE_LOAD_INT = 2'd0;
    localparam logic [1:0] MODE_LOAD_FIX = 2'd1;
    localparam logic [1:0] MODE_SCAN     = 2'd2;
    localparam logic [1:0] MODE_BLANK    = 2'd3;

    localparam logic [1:0] POINT_NONE  = 2'd0;
    localparam logic [1:0] POINT_TWO   = 2'd2;
    localparam logic [1:0] POINT_THREE = 2'd3;

    localparam logic [VALUE_W-1:0] INT_LIMIT   = 17'd9999;
    localparam logic [VALUE_W-1:0] FIXED_LIMIT = 17'd99999;
    localparam logic [VALUE_W-1:0] FIXED_SPLIT = 17'd10000;

    // reciprocals, quotient = (v * recip) >> shift, exact for 17-bit v
    localparam int PROD_W = 35;
    localparam logic [17:0] RECIP_10    = 18'd209716;
    localparam logic [17:0] RECIP_100   = 18'd167773;
    localparam logic [17:0] RECIP_1000  = 18'd134218;
    localparam logic [17:0] RECIP_10000 = 18'd214749;
    localparam int SHIFT_10    = 21;
    localparam int SHIFT_100   = 24;
    localparam int SHIFT_1000  = 27;
    localparam int SHIFT_10000 = 31;

    localparam int NIBBLES = 5;

    typedef struct packed {
        logic [1:0]               mode;
        logic [1:0]               sel;
        logic                     wide;
        logic [NIBBLES-1:0][3:0]  nib;
    } t_fsd_entry;

    function automatic logic [6:0] seg_font(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0: seg = 7'h3F;
            4'd1: seg = 7'h06;
            4'd2: seg = 7'h5B;
            4'd3: seg = 7'h4F;
            4'd4: seg = 7'h66;
            4'd5: seg = 7'h6D;
            4'd6: seg = 7'h7D;
            4'd7: seg = 7'h07;
            4'd8: seg = 7'h7F;
            4'd9: seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

FILE: hw/rtl/fsd_front.sv
// front end: accepts items, saturates loads and forms the decimal quotients
module fsd_front (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic [fsd_pkg::VALUE_W-1:0]   i_value,
    input  logic [1:0]                    i_sel,
    input  logic                          i_full,
    output logic                          o_push,
    output fsd_pkg::t_fsd_entry           o_entry
);
    import fsd_pkg::*;

    logic [VALUE_W-1:0] w_limit;
    logic [VALUE_W-1:0] w_v_sat;
    logic [PROD_W-1:0]  w_p1;
    logic [PROD_W-1:0]  w_p2;
    logic [PROD_W-1:0]  w_p3;
    logic [PROD_W-1:0]  w_p4;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign w_limit = (i_mode == MODE_LOAD_INT) ? INT_LIMIT : FIXED_LIMIT;
    assign w_v_sat = (i_value > w_limit) ? w_limit : i_value;

    assign w_p1 = PROD_W'(w_v_sat) * PROD_W'(RECIP_10);
    assign w_p2 = PROD_W'(w_v_sat) * PROD_W'(RECIP_100);
    assign w_p3 = PROD_W'(w_v_sat) * PROD_W'(RECIP_1000);
    assign w_p4 = PROD_W'(w_v_sat) * PROD_W'(RECIP_10000);

    always_comb begin
        o_entry.mode   = i_mode;
        o_entry.sel    = i_sel;
        o_entry.wide   = (i_mode == MODE_LOAD_FIX) && (w_v_sat >= FIXED_SPLIT);
        // low nibble of each quotient is all the digit split needs
        o_entry.nib[0] = w_v_sat[3:0];
        o_entry.nib[1] = w_p1[SHIFT_10+3:SHIFT_10];
        o_entry.nib[2] = w_p2[SHIFT_100+3:SHIFT_100];
        o_entry.nib[3] = w_p3[SHIFT_1000+3:SHIFT_1000];
        o_entry.nib[4] = w_p4[SHIFT_10000+3:SHIFT_10000];
    end

endmodule

FILE: hw/rtl/fsd_queue.sv
// short register queue between the front and back ends
`include "four_digit_seven_segment_driver_top_assert.svh"
module fsd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  fsd_pkg::t_fsd_entry   i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output fsd_pkg::t_fsd_entry   o_entry
);
    import fsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_fsd_entry       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `FSD_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `FSD_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_valid)
    `FSD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL)

endmodule

FILE: hw/rtl/fsd_back.sv
// back end: digit store, point place and registered scan and blank output
`include "four_digit_seven_segment_driver_top_assert.svh"
module fsd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fsd_pkg::t_fsd_entry   i_entry,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_segments,
    output logic [3:0]            o_digit_enable
);
    import fsd_pkg::*;

    logic [3:0] r_digit [4];
    logic [1:0] r_point;
    logic       r_out_valid;
    logic [7:0] r_segments;
    logic [3:0] r_digit_enable;

    logic [3:0] w_dec [NIBBLES];
    logic [3:0] w_ten [NIBBLES];
    logic       w_is_load;
    logic       w_out_free;
    logic [7:0] n_segments;
    logic [3:0] n_digit_enable;
    logic [1:0] n_point;

    // digit k = q_k - 10 * q_(k+1), taken mod 16
    always_comb begin
        for (int k = 0; k < NIBBLES; k++) begin
            w_ten[k] = '0;
        end
        for (int k = 0; k < NIBBLES - 1; k++) begin
            w_ten[k] = {i_entry.nib[k+1][0], 3'b000} + {i_entry.nib[k+1][2:0], 1'b0};
        end
        for (int k = 0; k < NIBBLES; k++) begin
            w_dec[k] = i_entry.nib[k] - w_ten[k];
        end
    end

    assign w_is_load  = (i_entry.mode == MODE_LOAD_INT) || (i_entry.mode == MODE_LOAD_FIX);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_pop      = i_valid && (w_is_load || w_out_free);

    always_comb begin
        case (i_entry.mode)
            MODE_SCAN: begin
                n_segments[6:0] = seg_font(r_digit[i_entry.sel]);
                n_segments[7]   = (r_point != POINT_NONE) && (r_point == i_entry.sel);
                n_digit_enable  = 4'b0001 << i_entry.sel;
            end
            default: begin
                n_segments     = '0;
                n_digit_enable = '0;
            end
        endcase
    end

    always_comb begin
        case (i_entry.mode)
            MODE_LOAD_INT: n_point = POINT_NONE;
            MODE_LOAD_FIX: n_point = i_entry.wide ? POINT_TWO : POINT_THREE;
            default:       n_point = r_point;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_digit[k] <= '0;
            end
            r_point     <= POINT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && w_is_load) begin
                for (int k = 0; k < 4; k++) begin
                    r_digit[k] <= i_entry.wide ? w_dec[k+1] : w_dec[k];
                end
                r_point <= n_point;
            end
            if (o_pop && !w_is_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !w_is_load) begin
            r_segments     <= n_segments;
            r_digit_enable <= n_digit_enable;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_segments     = r_segments;
    assign o_digit_enable = r_digit_enable;

    `FSD_ASSERT(a_enable_onehot, i_clk, i_rst_n, r_out_valid |-> $onehot0(r_digit_enable))
    `FSD_ASSERT(a_point_place, i_clk, i_rst_n,
        (r_out_valid && r_segments[7]) |-> (r_digit_enable[2] || r_digit_enable[3]))
    `FSD_ASSERT_NORST(a_reset_clears, i_clk, !i_rst_n |=> !r_out_valid)

endmodule

FILE: hw/rtl/four_digit_seven_segment_driver_top.sv
// top level of the four-digit multiplexed seven-segment display driver
// a scan or blank item is held in the queue, then in the back end's output register, before it shows on the output
// throughput: one item per cycle while the queue is not full, set by the combinational front multipliers and queue
// loads give no output item and update the digit store when they leave the queue
// synchronous active-low reset clears the digit store, the point place and the queue
module four_digit_seven_segment_driver_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // value[16:0], digit_select[18:17], zero pad
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // segments[7:0], digit_enable[11:8], zero pad
);
    import fsd_pkg::*;

    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_q_valid;
    t_fsd_entry w_front_entry;
    t_fsd_entry w_back_entry;
    logic [7:0] w_segments;
    logic [3:0] w_digit_enable;

    fsd_front u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_mode   (s_axis_tuser),
        .i_value  (s_axis_tdata[VALUE_W-1:0]),
        .i_sel    (s_axis_tdata[VALUE_W+1:VALUE_W]),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_entry  (w_front_entry)
    );

    fsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_front_entry),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_valid  (w_q_valid),
        .o_entry  (w_back_entry)
    );

    fsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_entry        (w_back_entry),
        .o_pop          (w_pop),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_segments     (w_segments),
        .o_digit_enable (w_digit_enable)
    );

    assign m_axis_tdata = {4'b0000, w_digit_enable, w_segments};

endmodule
